[src/rwf_pkg.sv]
`timescale 1ns / 1ps
package rwf_pkg;

    localparam int PIX_W = 24;

    // register indexes on the config port
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FILTER_MODE  = 2'd2;

    // filter modes
    localparam logic [1:0] MODE_MAX    = 2'd0;
    localparam logic [1:0] MODE_MEAN   = 2'd1;
    localparam logic [1:0] MODE_MEDIAN = 2'd2;

    // floor(x / 9) == (x * RECIP9) >> 16 for x up to 9 * 255
    localparam logic [12:0] RECIP9 = 13'd7282;

    typedef struct packed {
        logic [8:0][PIX_W-1:0] win;
        logic                  last;
    } rwf_entry_t;

    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] mid;
        logic [7:0] hi;
    } rwf_sort3_t;

    function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (c < lo) ? lo : ((c > hi) ? hi : c);
    endfunction

    function automatic rwf_sort3_t sort3(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        rwf_sort3_t s;
        s.lo  = min3(a, b, c);
        s.mid = med3(a, b, c);
        s.hi  = max3(a, b, c);
        return s;
    endfunction

endpackage

[src/rwf_front.sv]
`timescale 1ns / 1ps
module rwf_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                restart,
    input  logic [WW-1:0]       eff_w,
    input  logic [HW-1:0]       eff_h,
    input  logic                accept,
    input  logic                kind,
    input  logic [7:0]          red_in,
    input  logic [7:0]          green_in,
    input  logic [7:0]          blue_in,
    output logic                q_push,
    output rwf_pkg::rwf_entry_t q_entry
);
    import rwf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int OW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [OW-1:0] out_row_reg, out_row_next;
    logic [2:0][2:0][PIX_W-1:0] win_reg, win_next;

    // line store: {upper, middle} per column, one write and one read a cycle
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;

    logic [CW-1:0]      ic;
    logic [PIX_W-1:0]   pix;
    logic [2:0][PIX_W-1:0] col;
    logic               emit;
    logic               is_last;
    logic               ic_last;
    logic               col_first_out;
    logic               col_last_out;
    logic               row_first_out;
    logic               row_last_out;
    logic [2:0][2:0][PIX_W-1:0] cur;

    assign ic      = (WW'(in_col_reg) >= eff_w) ? '0 : in_col_reg;
    assign ic_last = (WW'(ic) == eff_w - WW'(1));
    assign pix     = (!kind && (in_row_reg < RW'(eff_h))) ? {red_in, green_in, blue_in} : '0;
    assign col[0]  = rd_reg[2*PIX_W-1:PIX_W];
    assign col[1]  = rd_reg[PIX_W-1:0];
    assign col[2]  = pix;
    assign emit    = (in_row_reg >= RW'(2)) || ((in_row_reg == RW'(1)) && (ic != '0));

    assign row_first_out = (out_row_reg == '0);
    assign row_last_out  = (HW'(out_row_reg) == eff_h - HW'(1));
    assign col_first_out = (out_col_reg == '0);
    assign col_last_out  = (WW'(out_col_reg) == eff_w - WW'(1));
    assign is_last       = row_last_out && col_last_out;

    // window as seen by the centre pixel, edges outside the frame zeroed
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            cur[r][0] = win_reg[r][1];
            cur[r][1] = win_reg[r][2];
            cur[r][2] = (ic == '0) ? '0 : col[r];
            if ((r == 0 && row_first_out) || (r == 2 && row_last_out))
            begin
                cur[r] = '0;
            end
            if (col_first_out)
            begin
                cur[r][0] = '0;
            end
            if (col_last_out)
            begin
                cur[r][2] = '0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            q_entry.win[i] = cur[i / 3][i % 3];
        end
        q_entry.last = is_last;
        q_push       = accept && emit && !restart;
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        win_next     = win_reg;
        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            win_next     = '0;
        end
        else if (accept)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r][0] = (ic == '0) ? '0 : win_reg[r][1];
                win_next[r][1] = (ic == '0) ? '0 : win_reg[r][2];
                win_next[r][2] = col[r];
            end
            if (ic_last)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end
            else
            begin
                in_col_next = ic + CW'(1);
            end
            if (emit)
            begin
                if (is_last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    win_next     = '0;
                end
                else if (col_last_out)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            win_reg     <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            win_reg     <= win_next;
        end
    end

    // read one column ahead; same-address write is forwarded (width of one)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[ic] <= {col[1], pix};
        end
        if (accept && (ic == in_col_next))
        begin
            rd_reg <= {col[1], pix};
        end
        else
        begin
            rd_reg <= line_mem[in_col_next];
        end
    end

`ifndef ASSERT_OFF
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(in_col_reg) < eff_w)
        else $error("input column beyond frame width");
    a_out_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        HW'(out_row_reg) < eff_h)
        else $error("output row beyond frame height");
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && is_last |=> (in_col_reg == '0) && (in_row_reg == '0) && (win_reg == '0))
        else $error("frame end did not restart the window");
`endif

endmodule

[src/rwf_queue.sv]
`timescale 1ns / 1ps
module rwf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rwf_pkg::rwf_entry_t wr_entry,
    output logic                full,
    input  logic                pop,
    output logic                valid,
    output rwf_pkg::rwf_entry_t rd_entry
);
    import rwf_pkg::*;

    rwf_entry_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign rd_entry = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

[src/rwf_back.sv]
`timescale 1ns / 1ps
module rwf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          mode,
    input  logic                head_valid,
    input  rwf_pkg::rwf_entry_t head_entry,
    output logic                head_pop,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          red_out,
    output logic [7:0]          green_out,
    output logic [7:0]          blue_out,
    output logic                frame_end
);
    import rwf_pkg::*;

    logic [2:0][11:0]            sum_comb, sum_reg;
    rwf_sort3_t [2:0][2:0]       row_comb, row_reg;
    logic                        s1_last_reg;
    logic                        s1_valid_reg, s1_valid_next;
    logic [2:0][7:0]             res_comb, res_reg;
    logic                        out_last_reg;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_ready;
    logic                        s1_adv;
    logic [2:0][24:0]            prod;

    assign out_ready = !out_valid_reg || pop;
    assign s1_adv    = s1_valid_reg && out_ready;
    assign head_pop  = head_valid && (!s1_valid_reg || out_ready);

    // stage 1: channel sums and sorted rows
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum_comb[k] = '0;
            for (int i = 0; i < 9; i++)
            begin
                sum_comb[k] = sum_comb[k] + 12'(head_entry.win[i][8*(2-k) +: 8]);
            end
            for (int r = 0; r < 3; r++)
            begin
                row_comb[k][r] = sort3(head_entry.win[3*r][8*(2-k) +: 8],
                                       head_entry.win[3*r+1][8*(2-k) +: 8],
                                       head_entry.win[3*r+2][8*(2-k) +: 8]);
            end
        end
    end

    // stage 2: pick the filter
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod[k] = 25'(sum_reg[k]) * 25'(RECIP9);
            unique case (mode)
                MODE_MEAN:
                begin
                    res_comb[k] = prod[k][23:16];
                end
                MODE_MEDIAN:
                begin
                    res_comb[k] = med3(max3(row_reg[k][0].lo, row_reg[k][1].lo, row_reg[k][2].lo),
                                       med3(row_reg[k][0].mid, row_reg[k][1].mid,
                                            row_reg[k][2].mid),
                                       min3(row_reg[k][0].hi, row_reg[k][1].hi, row_reg[k][2].hi));
                end
                default:
                begin
                    res_comb[k] = max3(row_reg[k][0].hi, row_reg[k][1].hi, row_reg[k][2].hi);
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next  = head_pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : ((pop && out_valid_reg) ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            sum_reg     <= sum_comb;
            row_reg     <= row_comb;
            s1_last_reg <= head_entry.last;
        end
        if (s1_adv)
        begin
            res_reg      <= res_comb;
            out_last_reg <= s1_last_reg;
        end
    end

    assign empty     = !out_valid_reg;
    assign red_out   = res_reg[0];
    assign green_out = res_reg[1];
    assign blue_out  = res_reg[2];
    assign frame_end = out_last_reg;

endmodule

[src/rgb_window_filter_3x3_unit.sv]
`timescale 1ns / 1ps
// RGB 3x3 window filter: max, mean (sum / 9, truncated) or median per channel.
// Input queue port: a beat is taken when push is high and full is low. kind 0
// carries a pixel, kind 1 is a drain tick. Pixels come in raster order; after
// the last pixel of a frame send frame_width + 1 drain beats to flush it.
// Output queue port: the oldest result sits on the outputs while empty is low
// and is taken when pop is high. frame_end marks the frame's last pixel.
// Throughput: one beat per clock on both sides while pop stays high; the line
// store is a single port-pair memory read one column ahead, so no stall is
// needed per pixel. A pixel's result is built when the beat frame_width + 1
// later is taken, then passes a queue slot and two back stages to the outputs.
// When the receiver stalls, the back stages and the 2-entry queue fill and full
// rises; nothing is lost. Config writes (cfg_we/cfg_index/cfg_data) are meant
// for idle time; width or height writes restart the frame. Reset: width 1024,
// height 1, mode max, window and positions cleared; line store is not cleared.
module rgb_window_filter_3x3_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic        frame_end
);
    import rwf_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [1:0]  mode_reg;
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic        restart;
    logic        accept;
    logic        q_push;
    logic        q_pop;
    logic        q_valid;
    rwf_entry_t  q_in;
    rwf_entry_t  q_out;

    // zero acts as one, large values saturate
    assign eff_w = (width_reg == '0) ? WW'(1) :
                   ((32'(width_reg) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_reg));
    assign eff_h = (height_reg == '0) ? HW'(1) :
                   ((32'(height_reg) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_reg));

    assign restart = cfg_we && ((cfg_index == REG_FRAME_WIDTH) ||
                                (cfg_index == REG_FRAME_HEIGHT));
    assign accept  = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1024;
            height_reg <= 13'd1;
            mode_reg   <= MODE_MAX;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
            begin
                width_reg <= cfg_data[10:0];
            end
            if (cfg_index == REG_FRAME_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
            if (cfg_index == REG_FILTER_MODE)
            begin
                mode_reg <= cfg_data[1:0];
            end
        end
    end

    rwf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (restart),
        .eff_w    (eff_w),
        .eff_h    (eff_h),
        .accept   (accept),
        .kind     (kind),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    rwf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_in),
        .full     (full),
        .pop      (q_pop),
        .valid    (q_valid),
        .rd_entry (q_out)
    );

    rwf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .head_valid (q_valid),
        .head_entry (q_out),
        .head_pop   (q_pop),
        .pop        (pop),
        .empty      (empty),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .frame_end  (frame_end)
    );

endmodule

[tb/rwf_checker.sv]
`timescale 1ns / 1ps
// Watches config, input and result ports, predicts every result and compares.
module rwf_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        push,
    input  logic        full,
    input  logic        kind,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  red_out,
    input  logic [7:0]  green_out,
    input  logic [7:0]  blue_out,
    input  logic        frame_end,
    output int          errors,
    output int          pending
);
    import rwf_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fend;
    } rgb_result_t;

    rgb_result_t         filtered_q[$];
    logic [PIX_W-1:0]    line_old[MAX_WIDTH];
    logic [PIX_W-1:0]    line_new[MAX_WIDTH];
    logic [PIX_W-1:0]    win[9];
    int                  col_in, row_in, col_out, row_out;
    logic [10:0]         width_reg;
    logic [12:0]         height_reg;
    logic [1:0]          mode_reg;

    function automatic int eff_width();
        int w;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = height_reg;
        if (h == 0) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    task automatic restart_frame();
        col_in = 0;
        row_in = 0;
        col_out = 0;
        row_out = 0;
        for (int i = 0; i < 9; i++) win[i] = '0;
    endtask

    // max, truncated mean or median of nine bytes
    function automatic logic [7:0] filter9(input logic [7:0] v[9], input logic [1:0] m);
        logic [7:0] a[9];
        logic [7:0] t;
        int         sum;
        int         j;
        sum = 0;
        if (m == MODE_MEAN) begin
            for (int i = 0; i < 9; i++) sum += v[i];
            return 8'(sum / 9);
        end
        if (m == MODE_MEDIAN) begin
            a = v;
            for (int i = 1; i < 9; i++) begin
                t = a[i];
                j = i;
                while (j > 0 && a[j-1] > t) begin
                    a[j] = a[j-1];
                    j--;
                end
                a[j] = t;
            end
            return a[4];
        end
        t = 0;
        for (int i = 0; i < 9; i++) if (v[i] > t) t = v[i];
        return t;
    endfunction

    task automatic predict_beat(input logic k, input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b);
        int               w, h, ic, ir, rr, cc;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] colv[3];
        logic [PIX_W-1:0] cur[9];
        logic [7:0]       chan[9];
        logic [7:0]       res[3];
        logic             emit, last;
        rgb_result_t      e;
        w = eff_width();
        h = eff_height();
        ic = (col_in >= w) ? 0 : col_in;
        ir = row_in;
        pix = (!k && ir < h) ? {r, g, b} : '0;
        colv[0] = line_old[ic];
        colv[1] = line_new[ic];
        colv[2] = pix;
        line_old[ic] = line_new[ic];
        line_new[ic] = pix;
        emit = (ir >= 2) || (ir == 1 && ic >= 1);
        for (int i = 0; i < 3; i++) begin
            if (ic == 0) begin
                // previous row's last pixel in the center: right column is off frame
                cur[i*3]   = win[i*3+1];
                cur[i*3+1] = win[i*3+2];
                cur[i*3+2] = '0;
                win[i*3]   = '0;
                win[i*3+1] = '0;
            end else begin
                win[i*3]   = win[i*3+1];
                win[i*3+1] = win[i*3+2];
            end
            win[i*3+2] = colv[i];
            if (ic != 0) begin
                cur[i*3]   = win[i*3];
                cur[i*3+1] = win[i*3+1];
                cur[i*3+2] = win[i*3+2];
            end
        end
        ic++;
        if (ic >= w) begin
            ic = 0;
            ir++;
        end
        col_in = ic;
        row_in = ir;
        if (!emit) return;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rr = row_out + i;
                cc = col_out + j;
                if (rr < 1 || rr > h || cc < 1 || cc > w) cur[i*3+j] = '0;
            end
        end
        for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < 9; i++) chan[i] = cur[i][16-8*c +: 8];
            res[c] = filter9(chan, mode_reg);
        end
        last = (row_out == h - 1) && (col_out == w - 1);
        e.red = res[0];
        e.green = res[1];
        e.blue = res[2];
        e.fend = last;
        filtered_q = {filtered_q, e};
        if (last) restart_frame();
        else begin
            col_out++;
            if (col_out >= w) begin
                col_out = 0;
                row_out++;
            end
        end
    endtask

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10) $display("%0t ERROR: %s", $realtime, msg);
    endtask

    task automatic check_result();
        rgb_result_t e;
        if (filtered_q.size() == 0) begin
            note_error($sformatf("result %h %h %h end=%b with nothing expected",
                                 red_out, green_out, blue_out, frame_end));
            return;
        end
        e = filtered_q.pop_front();
        if (red_out !== e.red || green_out !== e.green || blue_out !== e.blue
            || frame_end !== e.fend)
            note_error($sformatf("rgb %h %h %h end=%b, expected %h %h %h end=%b",
                                 red_out, green_out, blue_out, frame_end,
                                 e.red, e.green, e.blue, e.fend));
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg = 11'd1024;
            height_reg = 13'd1;
            mode_reg = MODE_MAX;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                line_old[i] = '0;
                line_new[i] = '0;
            end
            restart_frame();
            filtered_q.delete();
            pending <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_FRAME_WIDTH: begin
                        width_reg = cfg_data[10:0];
                        restart_frame();
                    end
                    REG_FRAME_HEIGHT: begin
                        height_reg = cfg_data;
                        restart_frame();
                    end
                    REG_FILTER_MODE: mode_reg = cfg_data[1:0];
                    default: ;
                endcase
            end
            // a popped result can never stem from this edge's input beat
            if (pop && !empty) check_result();
            if (push && !full) predict_beat(kind, red_in, green_in, blue_in);
            pending <= filtered_q.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Top: clock, reset, stimulus and verdict. Prediction lives in rwf_checker.
module tb;
    import rwf_pkg::*;

    localparam logic [1:0] REG_SPARE  = 2'd3;   // unmapped index, must be ignored
    localparam logic [1:0] MODE_SPARE = 2'd3;   // behaves as maximum
    localparam int RAND_BEATS = 340;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        push;
    logic        full;
    logic        kind;
    logic [7:0]  red_in, green_in, blue_in;
    logic        empty;
    logic        pop;
    logic [7:0]  red_out, green_out, blue_out;
    logic        frame_end;
    int          errors;
    int          pending;
    int          beats;
    int          cycles;
    logic        push_steady;

    rgb_window_filter_3x3_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .empty     (empty),
        .pop       (pop),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end)
    );

    rwf_checker i_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .empty     (empty),
        .pop       (pop),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Receiver: stalls ~36% of cycles, except for one long window of steady pops
    always @(negedge clk) begin
        cycles <= cycles + 1;
        pop <= (cycles > 300 && cycles < 700) || ($urandom_range(99) >= 36);
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Drain the result side, then give the pipe time to settle before a config write
    task automatic wait_idle();
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        cfg_we = 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic setup(input int w, input int h, input logic [1:0] m);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 13'(w));
        write_reg(REG_FRAME_HEIGHT, 13'(h));
        write_reg(REG_FILTER_MODE, 13'(m));
    endtask

    // One input beat; returns after the handshake, at a falling edge
    task automatic send(input logic k, input logic [7:0] r, input logic [7:0] g,
                        input logic [7:0] b);
        while (!push_steady && $urandom_range(99) < 36) begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        kind <= k;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
        push = 1'b0;
        beats++;
        push_steady = beats > 150 && beats < 300;
    endtask

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // w*h pixels (a few drain ticks mixed in, acting as black), then w+1 flush
    // beats; flush beats sometimes carry a pixel, which is past the frame and dropped.
    // With cut >= 0 the frame stops after that many beats.
    task automatic run_frame(input int w, input int h, input int cut);
        int n;
        n = 0;
        for (int i = 0; i < w * h + w + 1; i++) begin
            if (cut >= 0 && n >= cut) return;
            if (i < w * h)
                send($urandom_range(19) == 0, rand_chan(), rand_chan(), rand_chan());
            else
                send($urandom_range(4) != 0, rand_chan(), rand_chan(), rand_chan());
            n++;
        end
    endtask

    initial begin
        int w, h, start;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = '0;
        push = 1'b0;
        kind = 1'b0;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        pop = 1'b0;
        cycles = 0;
        beats = 0;
        push_steady = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: 3x2 frame in each mode, extreme channel values, one drain
        // tick inside the frame acting as a black pixel
        for (int m = 0; m < 4; m++) begin
            setup(3, 2, 2'(m));
            for (int i = 0; i < 6; i++)
                send(i == 4, (i & 1) ? 8'hff : 8'h00, (i & 2) ? 8'hff : 8'h00,
                     (i == 5) ? 8'hff : 8'h80);
            for (int i = 0; i < 4; i++) send(1'b1, 8'h00, 8'h00, 8'h00);
        end
        // unmapped register write must change nothing
        wait_idle();
        write_reg(REG_SPARE, 13'h1fff);
        run_frame(3, 2, -1);

        // Random frames, mostly small; some cut short and restarted by config
        start = beats;
        while (beats - start < RAND_BEATS) begin
            w = ($urandom_range(9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            h = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 12);
            setup(w, h, 2'($urandom_range(3)));
            for (int f = $urandom_range(1, 3); f > 0; f--) begin
                if ($urandom_range(9) == 0) begin
                    run_frame(w, h, $urandom_range(w * h + w));
                    break;
                end
                run_frame(w, h, -1);
                if ($urandom_range(3) == 0) begin
                    // mode change only, no restart
                    wait_idle();
                    write_reg(REG_FILTER_MODE, 13'($urandom_range(3)));
                end
            end
        end
        // sender holds off until the result side is empty
        wait_idle();
        run_frame(4, 3, -1);

        // Register extremes: width and height zero, saturating values; the wide and
        // tall frames are cut short, all but the last restarted by the next setup
        setup(0, 0, MODE_MEDIAN);
        run_frame(1, 1, -1);
        setup(2047, 1, MODE_MEAN);
        run_frame(1024, 1, 40);
        setup(1, 8191, MODE_SPARE);
        run_frame(1, 4096, 60);
        setup(1024, 2, MODE_MAX);
        run_frame(1024, 2, 40);

        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
